@@ design/crc_framed_packet_decoder_defines.svh @@
// assertion macros shared by the packet decoder modules
// no dependencies; taken in by `include where checks are written
`ifndef CRC_FRAMED_PACKET_DECODER_DEFINES_SVH
`define CRC_FRAMED_PACKET_DECODER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CFPD_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CFPD_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/cfpd_pkg.sv @@
// shared types, constants and the crc byte update for the packet decoder
// no dependencies; used by cfpd_ctrl, cfpd_datapath and the top level
`default_nettype none

package cfpd_pkg;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TRUNC   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_BADCRC  = 2'd3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] MAGIC_A = 8'hEC;
    localparam logic [7:0] MAGIC_B = 8'h55;

    // header layout, byte positions in the frame
    localparam logic [6:0] POS_MAGIC_A = 7'd0;
    localparam logic [6:0] POS_MAGIC_B = 7'd1;
    localparam logic [6:0] POS_CHANNEL = 7'd2;
    localparam logic [6:0] POS_DIR     = 7'd3;
    localparam logic [6:0] POS_SEQ0    = 7'd4;
    localparam logic [6:0] POS_SEQ1    = 7'd5;
    localparam logic [6:0] POS_SEQ2    = 7'd6;
    localparam logic [6:0] POS_SEQ3    = 7'd7;
    localparam logic [6:0] POS_LENGTH  = 7'd8;
    localparam logic [6:0] HDR_BYTES   = 7'd9;
    localparam logic [6:0] MIN_FRAME   = 7'd11;
    localparam logic [6:0] COUNT_MAX   = 7'd127;

    localparam int OUT_TDATA_W = 72;

    // controller to datapath
    typedef struct packed {
        logic accept;  // take one input byte
        logic judge;   // latch status after the final byte
        logic read;    // read payload store at current index
        logic load;    // load the output register
        logic clear;   // return frame state to reset values
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic single;     // judged frame gives one result only
        logic last_item;  // the result being loaded is the final one
        logic out_free;   // output register can take a result
    } t_dp_stat;

    // crc-16/ccitt-false, one byte, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ design/cfpd_ctrl.sv @@
// frame sequencer: receive, judge, then step through the result beats
// depends on cfpd_pkg and crc_framed_packet_decoder_defines.svh
`default_nettype none
`include "crc_framed_packet_decoder_defines.svh"

module cfpd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_last,
    output logic                   o_in_ready,
    input  wire cfpd_pkg::t_dp_stat i_stat,
    output cfpd_pkg::t_dp_cmd      o_cmd
);

    localparam logic [1:0] S_RECV  = 2'd0;
    localparam logic [1:0] S_JUDGE = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_LOAD  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_RECV: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_JUDGE;
                end
            end
            S_JUDGE: begin
                o_cmd.judge = 1'b1;
                n_state     = i_stat.single ? S_LOAD : S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.last_item) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_RECV;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_RECV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RECV;
        end else begin
            r_state <= n_state;
        end
    end

    `CFPD_CHECK_NEXT(a_read_then_load, i_clk, i_rst_n, o_cmd.read, r_state == S_LOAD, "read not followed by load")
    `CFPD_CHECK(a_clear_on_load, i_clk, i_rst_n, o_cmd.clear, o_cmd.load && i_stat.last_item, "clear without final load")
    `CFPD_CHECK(a_load_needs_room, i_clk, i_rst_n, o_cmd.load, i_stat.out_free, "load into busy output")

endmodule

`default_nettype wire

@@ design/cfpd_datapath.sv @@
// frame datapath: crc, header capture, payload store, judge and output register
// depends on cfpd_pkg and crc_framed_packet_decoder_defines.svh
`default_nettype none
`include "crc_framed_packet_decoder_defines.svh"

module cfpd_datapath #(
    parameter int PAYLOAD_MAX = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire cfpd_pkg::t_dp_cmd     i_cmd,
    input  wire logic [7:0]            i_rx_byte,
    input  wire logic                  i_out_ready,
    output cfpd_pkg::t_dp_stat         o_stat,
    output logic                       o_out_valid,
    output logic [cfpd_pkg::OUT_TDATA_W-1:0] o_out_data,
    output logic                       o_out_last,
    output logic                       o_out_byte_valid
);

    localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    // frame state
    logic [6:0]  r_count;
    logic [15:0] r_crc;
    logic [15:0] r_tail;
    logic        r_magic_ok;
    logic [7:0]  r_channel;
    logic [7:0]  r_dir;
    logic [31:0] r_seq;
    logic [7:0]  r_len;

    logic [7:0]  r_store [PAYLOAD_MAX];
    logic [7:0]  r_rd_data;

    // judged result and emit index
    logic [1:0]  r_status;
    logic        r_single;
    logic [5:0]  r_idx;

    // output register
    logic        r_o_valid;
    logic [1:0]  r_o_status;
    logic [7:0]  r_o_channel;
    logic [7:0]  r_o_dir;
    logic [31:0] r_o_seq;
    logic [5:0]  r_o_len;
    logic [7:0]  r_o_pbyte;
    logic [4:0]  r_o_pidx;
    logic        r_o_byte_valid;
    logic        r_o_last;

    logic [6:0]  wr_off;
    logic        wr_en;
    logic [15:0] want_crc;
    logic [8:0]  want_count;
    logic [1:0]  judged;
    logic        out_free;
    logic        last_item;

    assign wr_off = r_count - cfpd_pkg::HDR_BYTES;
    assign wr_en  = i_cmd.accept && (r_count >= cfpd_pkg::HDR_BYTES)
                    && (wr_off < 7'(PAYLOAD_MAX));

    // crc travels low byte first
    assign want_crc   = {r_tail[7:0], r_tail[15:8]};
    assign want_count = {2'b00, cfpd_pkg::MIN_FRAME} + {1'b0, r_len};

    always_comb begin
        if (r_count < cfpd_pkg::MIN_FRAME) begin
            judged = cfpd_pkg::ST_TRUNC;
        end else if (!r_magic_ok || (r_len > 8'(PAYLOAD_MAX))) begin
            judged = cfpd_pkg::ST_INVALID;
        end else if ({2'b00, r_count} != want_count) begin
            judged = cfpd_pkg::ST_TRUNC;
        end else if (r_crc != want_crc) begin
            judged = cfpd_pkg::ST_BADCRC;
        end else begin
            judged = cfpd_pkg::ST_OK;
        end
    end

    assign out_free  = !r_o_valid || i_out_ready;
    assign last_item = r_single || (r_idx == (r_len[5:0] - 6'd1));

    assign o_stat.single    = (judged != cfpd_pkg::ST_OK) || (r_len == 8'd0);
    assign o_stat.last_item = last_item;
    assign o_stat.out_free  = out_free;

    // byte intake and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count    <= '0;
            r_crc      <= cfpd_pkg::CRC_INIT;
            r_tail     <= '0;
            r_magic_ok <= 1'b1;
            r_channel  <= '0;
            r_dir      <= '0;
            r_seq      <= '0;
            r_len      <= '0;
        end else if (i_cmd.accept) begin
            // the byte two back enters the crc, so the crc bytes never do
            if (r_count >= 7'd2) begin
                r_crc <= cfpd_pkg::crc_byte(r_crc, r_tail[15:8]);
            end
            r_tail <= {r_tail[7:0], i_rx_byte};
            case (r_count)
                cfpd_pkg::POS_MAGIC_A: begin
                    if (i_rx_byte != cfpd_pkg::MAGIC_A) r_magic_ok <= 1'b0;
                end
                cfpd_pkg::POS_MAGIC_B: begin
                    if (i_rx_byte != cfpd_pkg::MAGIC_B) r_magic_ok <= 1'b0;
                end
                cfpd_pkg::POS_CHANNEL: r_channel     <= i_rx_byte;
                cfpd_pkg::POS_DIR:     r_dir         <= i_rx_byte;
                cfpd_pkg::POS_SEQ0:    r_seq[7:0]    <= i_rx_byte;
                cfpd_pkg::POS_SEQ1:    r_seq[15:8]   <= i_rx_byte;
                cfpd_pkg::POS_SEQ2:    r_seq[23:16]  <= i_rx_byte;
                cfpd_pkg::POS_SEQ3:    r_seq[31:24]  <= i_rx_byte;
                cfpd_pkg::POS_LENGTH:  r_len         <= i_rx_byte;
                default: begin
                end
            endcase
            if (r_count != cfpd_pkg::COUNT_MAX) begin
                r_count <= r_count + 7'd1;
            end
        end
    end

    // payload store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_off[AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.read) begin
            r_rd_data <= r_store[r_idx[AW-1:0]];
        end
    end

    // judged status and emit index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= cfpd_pkg::ST_OK;
            r_single <= 1'b0;
            r_idx    <= '0;
        end else if (i_cmd.judge) begin
            r_status <= judged;
            r_single <= (judged != cfpd_pkg::ST_OK) || (r_len == 8'd0);
            r_idx    <= '0;
        end else if (i_cmd.load) begin
            r_idx <= r_idx + 6'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_status <= r_status;
            r_o_last   <= last_item;
            if (r_status != cfpd_pkg::ST_OK) begin
                r_o_channel    <= '0;
                r_o_dir        <= '0;
                r_o_seq        <= '0;
                r_o_len        <= '0;
                r_o_pbyte      <= '0;
                r_o_pidx       <= '0;
                r_o_byte_valid <= 1'b0;
            end else if (r_single) begin
                r_o_channel    <= r_channel;
                r_o_dir        <= r_dir;
                r_o_seq        <= r_seq;
                r_o_len        <= '0;
                r_o_pbyte      <= '0;
                r_o_pidx       <= '0;
                r_o_byte_valid <= 1'b0;
            end else begin
                r_o_channel    <= r_channel;
                r_o_dir        <= r_dir;
                r_o_seq        <= r_seq;
                r_o_len        <= r_len[5:0];
                r_o_pbyte      <= r_rd_data;
                r_o_pidx       <= r_idx[4:0];
                r_o_byte_valid <= 1'b1;
            end
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_out_last       = r_o_last;
    assign o_out_byte_valid = r_o_byte_valid;
    assign o_out_data       = {3'b000, r_o_pidx, r_o_pbyte, r_o_len, r_o_seq,
                               r_o_dir, r_o_channel, r_o_status};

    `CFPD_CHECK(a_byte_only_ok, i_clk, i_rst_n, r_o_valid && r_o_byte_valid, r_o_status == cfpd_pkg::ST_OK, "payload beat with error status")
    `CFPD_CHECK(a_error_single, i_clk, i_rst_n, r_o_valid && (r_o_status != cfpd_pkg::ST_OK), r_o_last && (r_o_seq == 32'd0), "error beat not a lone final beat")
    `CFPD_CHECK_NEXT(a_count_grows, i_clk, i_rst_n, i_cmd.accept && !i_cmd.clear, r_count >= $past(r_count), "byte count went backward")

endmodule

`default_nettype wire

@@ design/crc_framed_packet_decoder.sv @@
// top level of the crc framed packet decoder
// depends on cfpd_pkg, cfpd_ctrl and cfpd_datapath
//
// usage:
//   s_axis carries the received buffer one byte per beat; tlast marks the
//   final byte. bytes are taken at one per cycle while a buffer is coming in.
//   after the final byte the block judges the frame, then emits results on
//   m_axis: one per payload byte for a good frame, else a single beat (empty
//   payload, or error status with other fields zero). each payload beat
//   takes a payload store read, then an output register load; a single-beat
//   result goes from the judge straight to the output register load.
//   s_axis_tready is low from the final byte until the last result of that
//   buffer sits in the output register; the next buffer may then start while
//   that beat still waits. m_axis_tlast is set on the final result.
//   a stall on m_axis holds the output register and pauses the sequencer.
//   reset (synchronous, active low) empties the output register and returns
//   the frame state to its start; the payload store is not cleared.
`default_nettype none

module crc_framed_packet_decoder #(
    parameter int PAYLOAD_MAX = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // rx_byte
    input  wire logic        s_axis_tlast,  // end_of_buffer
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[1:0] channel[9:2] direction[17:10] sequence_res[49:18]
    // payload_length[55:50] payload_byte[63:56] payload_index[68:64] zero[71:69]
    output logic [cfpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic             m_axis_tuser,  // byte_valid
    output logic             m_axis_tlast   // last
);

    cfpd_pkg::t_dp_cmd  cmd;
    cfpd_pkg::t_dp_stat stat;

    cfpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cfpd_datapath #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_rx_byte        (s_axis_tdata),
        .i_out_ready      (m_axis_tready),
        .o_stat           (stat),
        .o_out_valid      (m_axis_tvalid),
        .o_out_data       (m_axis_tdata),
        .o_out_last       (m_axis_tlast),
        .o_out_byte_valid (m_axis_tuser)
    );

endmodule

`default_nettype wire

@@ bench/cfpd_check_pkg.sv @@
// result predictor and scoreboard for the crc framed packet decoder bench
// depends on cfpd_pkg for status codes, header positions and magic values
package cfpd_check_pkg;

    import cfpd_pkg::*;

    localparam int PAYLOAD_MAX = 32;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  channel;
        logic [7:0]  direction;
        logic [31:0] seq;
        logic [5:0]  length;
        logic [7:0]  pbyte;
        logic [4:0]  pindex;
        logic        valid;
        logic        last;
    } result_t;

    // crc-16/ccitt-false, bit serial, msb first
    function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    class packet_checker;
        int unsigned count;
        logic [15:0] crc;
        logic [15:0] tail;   // last two bytes, older one high
        bit          magic_good;
        logic [7:0]  chan;
        logic [7:0]  dir;
        logic [31:0] seq;
        logic [7:0]  len;
        logic [7:0]  store [PAYLOAD_MAX];
        result_t     pending [$];
        int          errors;
        int          beats;

        function new();
            errors = 0;
            beats  = 0;
            clear();
        endfunction

        function void clear();
            count      = 0;
            crc        = CRC_INIT;
            tail       = '0;
            magic_good = 1'b1;
            chan       = '0;
            dir        = '0;
            seq        = '0;
            len        = '0;
        endfunction

        // one accepted input beat; on the final byte the frame is judged
        function void take_byte(logic [7:0] b, logic eob);
            int unsigned pos;
            logic [15:0] want;
            logic [1:0]  verdict;
            result_t     r;
            pos = count;
            // crc bytes never enter the sum: each byte goes in two places late
            if (pos >= 2) crc = crc16_update(crc, tail[15:8]);
            tail = {tail[7:0], b};
            if (pos == POS_MAGIC_A && b != MAGIC_A) magic_good = 1'b0;
            if (pos == POS_MAGIC_B && b != MAGIC_B) magic_good = 1'b0;
            if (pos == POS_CHANNEL) chan = b;
            if (pos == POS_DIR) dir = b;
            if (pos >= POS_SEQ0 && pos <= POS_SEQ3) seq[8*(pos - POS_SEQ0) +: 8] = b;
            if (pos == POS_LENGTH) len = b;
            if (pos >= HDR_BYTES && pos - HDR_BYTES < PAYLOAD_MAX) store[pos - HDR_BYTES] = b;
            if (count < COUNT_MAX) count++;
            if (!eob) return;

            want = {tail[7:0], tail[15:8]};
            if (count < MIN_FRAME)                        verdict = ST_TRUNC;
            else if (!magic_good || len > PAYLOAD_MAX)    verdict = ST_INVALID;
            else if (count != int'(MIN_FRAME) + int'(len)) verdict = ST_TRUNC;
            else if (crc != want)                         verdict = ST_BADCRC;
            else                                          verdict = ST_OK;

            if (verdict != ST_OK || len == 0) begin
                r        = '0;
                r.status = verdict;
                r.last   = 1'b1;
                if (verdict == ST_OK) begin
                    r.channel   = chan;
                    r.direction = dir;
                    r.seq       = seq;
                end
                pending.push_back(r);
            end else begin
                for (int i = 0; i < int'(len); i++) begin
                    r           = '0;
                    r.status    = ST_OK;
                    r.channel   = chan;
                    r.direction = dir;
                    r.seq       = seq;
                    r.length    = len[5:0];
                    r.pbyte     = store[i];
                    r.pindex    = i[4:0];
                    r.valid     = 1'b1;
                    r.last      = (i == int'(len) - 1);
                    pending.push_back(r);
                end
            end
            clear();
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= MAX_REPORTS) $display("mismatch %0d: %s", errors, what);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
                flag($sformatf("beat %0d %s: expected 0x%0h, got 0x%0h",
                               beats, name, want, got));
        endfunction

        // one accepted result beat against the oldest expectation
        function void check_beat(logic [OUT_TDATA_W-1:0] data, logic user, logic lst);
            result_t exp_r;
            beats++;
            if (pending.size() == 0) begin
                flag($sformatf("beat %0d arrived with nothing expected", beats));
                return;
            end
            exp_r = pending.pop_front();
            compare_field("status", 32'(exp_r.status), 32'(data[1:0]));
            compare_field("channel", 32'(exp_r.channel), 32'(data[9:2]));
            compare_field("direction", 32'(exp_r.direction), 32'(data[17:10]));
            compare_field("sequence", exp_r.seq, data[49:18]);
            compare_field("payload_length", 32'(exp_r.length), 32'(data[55:50]));
            compare_field("payload_byte", 32'(exp_r.pbyte), 32'(data[63:56]));
            compare_field("payload_index", 32'(exp_r.pindex), 32'(data[68:64]));
            compare_field("pad", 32'd0, 32'(data[71:69]));
            compare_field("byte_valid", 32'(exp_r.valid), 32'(user));
            compare_field("last", 32'(exp_r.last), 32'(lst));
        endfunction
    endclass

endpackage

@@ bench/tb_crc_framed_packet_decoder.sv @@
// top of the crc framed packet decoder bench: clock, reset, stream drivers
// and monitors; depends on cfpd_pkg, cfpd_check_pkg and the decoder rtl
module tb_crc_framed_packet_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import cfpd_pkg::*;
    import cfpd_check_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int RANDOM_BYTES  = 50;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 80;

    typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_HALF, RX_DUTY} rx_mode_t;
    typedef enum logic [1:0] {MANGLE_FLIP, MANGLE_DROP, MANGLE_EXTRA, MANGLE_CUT} mangle_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // rx_byte
    logic                   s_axis_tlast;   // end_of_buffer
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // status, channel, direction, sequence_res, payload_length,
    // payload_byte, payload_index, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;   // byte_valid
    logic                   m_axis_tlast;   // last

    packet_checker pkt_chk = new();

    logic [7:0]  frame_buf [$];
    int unsigned burst_left;
    int unsigned bytes_sent;
    int unsigned hold_trigger;
    int unsigned cycles;

    crc_framed_packet_decoder #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb_crc_framed_packet_decoder: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            pkt_chk.take_byte(s_axis_tdata, s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            pkt_chk.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // receiver: changing stall patterns, plus a long hold-off on request
    initial begin
        rx_mode_t    mode;
        int unsigned mode_left;
        int unsigned hold_seen;
        int unsigned hold_left;
        m_axis_tready = 1'b0;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_trigger != hold_seen) begin
                hold_seen = hold_trigger;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    RX_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
                    default:   m_axis_tready <= ((mode_left % 8) < 3);
                endcase
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eob);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eob;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 40);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(0, 255));
            s_axis_tlast  <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_buffer();
        foreach (frame_buf[k]) send_byte(frame_buf[k], k == frame_buf.size() - 1);
    endtask

    // sender pauses until every predicted result has been seen
    task automatic drain_results();
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pkt_chk.pending.size() != 0);
    endtask

    // well-formed frame in frame_buf; fill below zero means random payload
    function automatic void make_frame(input logic [7:0] chan, input logic [7:0] dir,
                                       input logic [31:0] seq, input int len, input int fill);
        logic [15:0] crc;
        frame_buf = {};
        frame_buf.push_back(MAGIC_A);
        frame_buf.push_back(MAGIC_B);
        frame_buf.push_back(chan);
        frame_buf.push_back(dir);
        for (int k = 0; k < 4; k++) frame_buf.push_back(seq[8*k +: 8]);
        frame_buf.push_back(len[7:0]);
        for (int k = 0; k < len; k++)
            frame_buf.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : fill[7:0]);
        crc = CRC_INIT;
        foreach (frame_buf[k]) crc = crc16_update(crc, frame_buf[k]);
        frame_buf.push_back(crc[7:0]);
        frame_buf.push_back(crc[15:8]);
    endfunction

    function automatic void mangle_frame();
        mangle_t     kind;
        int unsigned idx;
        int unsigned keep;
        kind = mangle_t'($urandom_range(0, 3));
        idx  = $urandom_range(0, frame_buf.size() - 1);
        case (kind)
            MANGLE_FLIP:  frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
            MANGLE_DROP:  frame_buf.delete(idx);
            MANGLE_EXTRA: frame_buf.insert(idx, 8'($urandom_range(0, 255)));
            default: begin
                keep = $urandom_range(1, frame_buf.size() - 1);
                while (frame_buf.size() > keep) void'(frame_buf.pop_back());
            end
        endcase
    endfunction

    function automatic void make_noise(input int n);
        frame_buf = {};
        repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    initial begin
        int unsigned pick;
        int          len;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        burst_left    = 0;
        bytes_sent    = 0;
        hold_trigger  = 0;
        cycles        = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty payload, all-zero header
        make_frame(8'h00, 8'h00, 32'h0000_0000, 0, 0);
        send_buffer();
        // full payload, all-ones everywhere
        make_frame(8'hFF, 8'hFF, 32'hFFFF_FFFF, PAYLOAD_MAX, 8'hFF);
        send_buffer();
        make_frame(8'h5A, 8'hA5, 32'h1234_5678, 1, -1);
        send_buffer();
        // length field above the maximum, on short frames
        make_frame(8'h01, 8'h02, 32'h0, 0, -1);
        frame_buf[POS_LENGTH] = 8'(PAYLOAD_MAX + 1);
        send_buffer();
        make_frame(8'h01, 8'h02, 32'h0, 0, -1);
        frame_buf[POS_LENGTH] = 8'hFF;
        send_buffer();
        // bad first and second magic byte
        make_frame(8'h10, 8'h20, 32'hDEAD_BEEF, 2, -1);
        frame_buf[POS_MAGIC_A] = ~MAGIC_A;
        send_buffer();
        make_frame(8'h10, 8'h20, 32'hDEAD_BEEF, 2, -1);
        frame_buf[POS_MAGIC_B] = MAGIC_A;
        send_buffer();
        // too short: one byte, then one short of the minimum
        frame_buf = {MAGIC_A};
        send_buffer();
        make_frame(8'h33, 8'h44, 32'h0, 0, -1);
        void'(frame_buf.pop_back());
        send_buffer();
        // total does not match the length field
        make_frame(8'h33, 8'h44, 32'h8000_0001, 3, -1);
        frame_buf.insert(POS_LENGTH + 1, 8'h77);
        send_buffer();
        // crc mismatch
        make_frame(8'h66, 8'h99, 32'h0F0F_F0F0, 4, -1);
        frame_buf[frame_buf.size() - 1] ^= 8'h80;
        send_buffer();
        // buffer long enough to saturate the byte count
        make_frame(8'h0C, 8'h0D, 32'h0, 0, -1);
        while (frame_buf.size() < 130) frame_buf.push_back(8'($urandom_range(0, 255)));
        send_buffer();
        drain_results();

        // long receiver hold-off while frames keep coming
        hold_trigger++;
        repeat (3) begin
            make_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom,
                       $urandom_range(2, 4), -1);
            send_buffer();
        end
        drain_results();

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, PAYLOAD_MAX)
                                               : $urandom_range(0, 6);
            make_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom,
                       len, -1);
            if (pick >= 90)      make_noise($urandom_range(1, 16));
            else if (pick >= 70) mangle_frame();
            send_buffer();
            if ($urandom_range(0, 7) == 0) drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pkt_chk.errors == 0 && pkt_chk.pending.size() == 0)
            $display("tb_crc_framed_packet_decoder: done, clean");
        else
            $display("tb_crc_framed_packet_decoder: done, errors");
        $finish;
    end

endmodule
